[design/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

[design/bhp_pkg.sv]
// types, codes and constants of the bitstream header parser
`default_nettype none

package bhp_pkg;

    localparam int HEADER_CHUNKS_DEF = 4;
    localparam int MAGIC_LEN         = 13;
    localparam int SIZE_BYTES        = 4;

    // parser phases
    localparam logic [3:0] PH_MAGIC   = 4'd0;
    localparam logic [3:0] PH_DESIG   = 4'd1;
    localparam logic [3:0] PH_LEN_HI  = 4'd2;
    localparam logic [3:0] PH_LEN_LO  = 4'd3;
    localparam logic [3:0] PH_SKIP    = 4'd4;
    localparam logic [3:0] PH_FINAL   = 4'd5;
    localparam logic [3:0] PH_SIZE    = 4'd6;
    localparam logic [3:0] PH_PAYLOAD = 4'd7;
    localparam logic [3:0] PH_ERROR   = 4'd8;

    // result kinds
    localparam logic [1:0] KIND_PAYLOAD  = 2'd0;
    localparam logic [1:0] KIND_HEADER   = 2'd1;
    localparam logic [1:0] KIND_MISMATCH = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data_byte;
        logic [31:0] config_size;
    } t_result;

    function automatic logic [7:0] magic_byte(input logic [3:0] pos);
        logic [7:0] v;
        unique case (pos)
            4'd0:    v = 8'h00;
            4'd1:    v = 8'h09;
            4'd2:    v = 8'h0F;
            4'd3:    v = 8'hF0;
            4'd4:    v = 8'h0F;
            4'd5:    v = 8'hF0;
            4'd6:    v = 8'h0F;
            4'd7:    v = 8'hF0;
            4'd8:    v = 8'h0F;
            4'd9:    v = 8'hF0;
            4'd10:   v = 8'h00;
            4'd11:   v = 8'h00;
            4'd12:   v = 8'h01;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/bhp_parser.sv]
// header parser state and per-byte next-state and result logic
`default_nettype none

module bhp_parser
    import bhp_pkg::*;
#(
    parameter int HEADER_CHUNKS = HEADER_CHUNKS_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte_value,
    input  wire logic       i_starts_file,
    output logic            o_res_valid,
    output t_result         o_res
);

    localparam logic [2:0] LastChunk = 3'(HEADER_CHUNKS);
    localparam logic [3:0] MagicLen  = 4'(MAGIC_LEN);
    localparam logic [3:0] SizeBytes = 4'(SIZE_BYTES);

    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_position, n_position;
    logic [2:0]  r_chunk, n_chunk;
    logic [15:0] r_skip, n_skip;
    logic [31:0] r_size, n_size;

    // state as seen by this byte: a file start behaves like reset
    logic [3:0]  c_phase, c_position;
    logic [2:0]  c_chunk, c_chunk_inc;
    logic [15:0] c_skip, c_skip_lo, c_skip_dec;
    logic [31:0] c_size, c_size_sh;
    logic [3:0]  c_pos_inc;
    logic [3:0]  c_after_chunk;

    always_comb begin
        c_phase    = i_starts_file ? PH_MAGIC : r_phase;
        c_position = i_starts_file ? 4'd0 : r_position;
        c_chunk    = i_starts_file ? 3'd0 : r_chunk;
        c_skip     = i_starts_file ? 16'd0 : r_skip;
        c_size     = i_starts_file ? 32'd0 : r_size;

        c_pos_inc     = c_position + 4'd1;
        c_chunk_inc   = c_chunk + 3'd1;
        c_skip_lo     = c_skip | {8'd0, i_byte_value};
        c_skip_dec    = c_skip - 16'd1;
        c_size_sh     = {c_size[23:0], i_byte_value};
        c_after_chunk = (c_chunk_inc >= LastChunk) ? PH_FINAL : PH_DESIG;

        n_phase     = c_phase;
        n_position  = c_position;
        n_chunk     = c_chunk;
        n_skip      = c_skip;
        n_size      = c_size;
        o_res_valid = 1'b0;
        o_res       = '0;

        unique case (c_phase)
            PH_MAGIC: begin
                if (c_position >= MagicLen || magic_byte(c_position) != i_byte_value) begin
                    n_phase     = PH_ERROR;
                    o_res_valid = 1'b1;
                    o_res.kind  = KIND_MISMATCH;
                end else if (c_pos_inc == MagicLen) begin
                    n_position = 4'd0;
                    n_chunk    = 3'd0;
                    n_phase    = PH_DESIG;
                end else begin
                    n_position = c_pos_inc;
                end
            end
            PH_DESIG: n_phase = PH_LEN_HI;
            PH_LEN_HI: begin
                n_skip  = {i_byte_value, 8'd0};
                n_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                n_skip = c_skip_lo;
                if (c_skip_lo == 16'd0) begin
                    n_chunk = c_chunk_inc;
                    n_phase = c_after_chunk;
                end else begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                n_skip = c_skip_dec;
                if (c_skip_dec == 16'd0) begin
                    n_chunk = c_chunk_inc;
                    n_phase = c_after_chunk;
                end
            end
            PH_FINAL: begin
                n_position = 4'd0;
                n_size     = 32'd0;
                n_phase    = PH_SIZE;
            end
            PH_SIZE: begin
                n_size = c_size_sh;
                if (c_pos_inc >= SizeBytes) begin
                    n_position        = 4'd0;
                    n_phase           = PH_PAYLOAD;
                    o_res_valid       = 1'b1;
                    o_res.kind        = KIND_HEADER;
                    o_res.config_size = c_size_sh;
                end else begin
                    n_position = c_pos_inc;
                end
            end
            PH_PAYLOAD: begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_PAYLOAD;
                o_res.data_byte = i_byte_value;
            end
            // mismatch phase and unused codes drop bytes until a file start
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_MAGIC;
            r_position <= 4'd0;
            r_chunk    <= 3'd0;
            r_skip     <= 16'd0;
            r_size     <= 32'd0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_position <= n_position;
            r_chunk    <= n_chunk;
            r_skip     <= n_skip;
            r_size     <= n_size;
        end
    end

endmodule

`default_nettype wire

[design/bhp_out_buf.sv]
// result register with a skid stage behind it
`default_nettype none

module bhp_out_buf
    import bhp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_push,
    input  wire t_result i_res,
    output logic         o_full,
    output logic         o_valid,
    input  wire logic    i_stall,
    output t_result      o_res
);

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;
    logic    c_main_free;

    assign c_main_free = !r_main_v || !i_stall;
    assign o_full      = r_skid_v;
    assign o_valid     = r_main_v;
    assign o_res       = r_main;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (c_main_free) begin
            r_main_v <= r_skid_v || i_push;
            r_skid_v <= 1'b0;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_main_free) begin
            r_main <= r_skid_v ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

endmodule

`default_nettype wire

[design/bitstream_header_parser.sv]
// Bitstream header parser, top level.
// Bytes of a configuration file enter on the input channel (i_in_valid,
// o_in_stall) with i_starts_file marking the first byte of a new file.
// The 13-byte magic prefix is checked, the header chunks and the final
// designator are skipped, and the 32-bit big-endian size is emitted once
// as a header result; every later byte comes out as a payload result.
// A wrong magic byte gives one mismatch result, then bytes are dropped
// until the next file start. Other header bytes give no result.
// A result is registered in the output buffer when its byte is taken,
// or in the skid entry if the receiver stalls. Throughput: one byte per
// cycle while o_in_stall is low, set by the parser state registers.
// The output holds a result register plus one skid entry, so a byte is
// still taken in the cycle the receiver first stalls; o_in_stall rises
// only when both entries are full and clears once the receiver drains.
// Reset (synchronous, active low) returns the parser to the magic check
// and empties the output buffer.
`default_nettype none
`include "assert_macros.svh"

module bitstream_header_parser
    import bhp_pkg::*;
#(
    parameter int HEADER_CHUNKS = HEADER_CHUNKS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_starts_file,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_data_byte,
    output logic [31:0]      o_config_size
);

    logic    c_accept;
    logic    c_res_valid;
    t_result c_res, c_out;

    assign c_accept = i_in_valid && !o_in_stall;

    bhp_parser #(
        .HEADER_CHUNKS (HEADER_CHUNKS)
    ) u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (c_accept),
        .i_byte_value  (i_byte_value),
        .i_starts_file (i_starts_file),
        .o_res_valid   (c_res_valid),
        .o_res         (c_res)
    );

    bhp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_accept && c_res_valid),
        .i_res   (c_res),
        .o_full  (o_in_stall),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (c_out)
    );

    assign o_kind        = c_out.kind;
    assign o_data_byte   = c_out.data_byte;
    assign o_config_size = c_out.config_size;

    // skid entry only fills behind a held result
    `ASSERT_IMPL(a_skid_behind_main, i_clk, i_rst_n, o_in_stall, o_out_valid)
    // input side backs up only when the receiver stalled
    `ASSERT_IMPL(a_stall_cause, i_clk, i_rst_n, $rose(o_in_stall), $past(i_out_stall))
    // only payload results carry a byte, only header results a size
    `ASSERT_IMPL(a_data_zero, i_clk, i_rst_n,
        o_out_valid && o_kind != KIND_PAYLOAD, o_data_byte == 8'd0)
    `ASSERT_IMPL(a_size_zero, i_clk, i_rst_n,
        o_out_valid && o_kind != KIND_HEADER, o_config_size == 32'd0)

endmodule

`default_nettype wire

[tb/bitstream_header_parser_tb.sv]
// testbench of the bitstream header parser: directed words, then random files and noise bursts
`timescale 1ns / 100ps

module bitstream_header_parser_tb;
    import bhp_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS   = 1400;
    localparam int CALM_FROM      = 1250;
    localparam int DIR_ROWS       = 21;

    localparam t_result NO_RES       = '0;
    localparam t_result MISMATCH_RES = '{KIND_MISMATCH, 8'h00, 32'h0};

    typedef struct packed {
        logic [7:0] b;
        logic       s;
        bit         pinned;
        t_result    res;
    } t_dir_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_byte_value = 8'h00;
    logic        i_starts_file = 1'b0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic [31:0] o_config_size;

    bitstream_header_parser #(
        .HEADER_CHUNKS(HEADER_CHUNKS_DEF)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_byte_value (i_byte_value),
        .i_starts_file(i_starts_file),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_kind       (o_kind),
        .o_data_byte  (o_data_byte),
        .o_config_size(o_config_size)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // parser state as the block should hold it
    logic [7:0]  magic_seq [MAGIC_LEN] = '{8'h00, 8'h09, 8'h0F, 8'hF0, 8'h0F, 8'hF0, 8'h0F,
                                           8'hF0, 8'h0F, 8'hF0, 8'h00, 8'h00, 8'h01};
    logic [3:0]  parse_phase = PH_MAGIC;
    logic [3:0]  byte_pos = '0;
    logic [2:0]  chunk_idx = '0;
    logic [15:0] skip_left = '0;
    logic [31:0] size_acc = '0;

    t_result pending_results [$];

    int  words_sent = 0;
    int  files_sent = 0;
    int  mon_errors = 0;
    int  seen_headers = 0;
    int  seen_mismatches = 0;
    int  seen_payload = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    bit  calm = 1'b0;

    // first row is the word right after reset
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{8'hFF, 1'b1, 1'b1, MISMATCH_RES},   // wrong first byte
        '{8'h00, 1'b0, 1'b0, NO_RES},         // dropped after mismatch
        '{8'h00, 1'b1, 1'b0, NO_RES},
        '{8'h09, 1'b0, 1'b0, NO_RES},
        '{8'h0F, 1'b0, 1'b0, NO_RES},
        '{8'h0F, 1'b0, 1'b1, MISMATCH_RES},   // wrong mid-magic byte
        '{8'h00, 1'b1, 1'b0, NO_RES},
        '{8'h09, 1'b0, 1'b0, NO_RES},
        '{8'h0F, 1'b0, 1'b0, NO_RES},
        '{8'hF0, 1'b0, 1'b0, NO_RES},
        '{8'h0F, 1'b0, 1'b0, NO_RES},
        '{8'hF0, 1'b0, 1'b0, NO_RES},
        '{8'h0F, 1'b0, 1'b0, NO_RES},
        '{8'hF0, 1'b0, 1'b0, NO_RES},
        '{8'h0F, 1'b0, 1'b0, NO_RES},
        '{8'hF0, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b0, NO_RES},
        '{8'h00, 1'b0, 1'b1, MISMATCH_RES},   // wrong last magic byte
        '{8'h01, 1'b0, 1'b0, NO_RES},         // still dropped
        '{8'hFF, 1'b1, 1'b1, MISMATCH_RES}    // restart out of the error phase
    };

    function automatic void next_chunk();
        chunk_idx = chunk_idx + 3'd1;
        if (chunk_idx >= HEADER_CHUNKS_DEF) parse_phase = PH_FINAL;
        else parse_phase = PH_DESIG;
    endfunction

    function automatic bit parse_byte(input logic [7:0] b, input logic s, output t_result res);
        bit hit;
        hit = 1'b0;
        res = '0;
        if (s) begin
            parse_phase = PH_MAGIC;
            byte_pos = '0;
            chunk_idx = '0;
            skip_left = '0;
            size_acc = '0;
        end
        case (parse_phase)
            PH_MAGIC: begin
                if (byte_pos >= MAGIC_LEN || magic_seq[byte_pos] != b) begin
                    parse_phase = PH_ERROR;
                    res.kind = KIND_MISMATCH;
                    hit = 1'b1;
                end else begin
                    byte_pos = byte_pos + 4'd1;
                    if (byte_pos == MAGIC_LEN) begin
                        byte_pos = '0;
                        chunk_idx = '0;
                        parse_phase = (HEADER_CHUNKS_DEF > 0) ? PH_DESIG : PH_FINAL;
                    end
                end
            end
            PH_DESIG: parse_phase = PH_LEN_HI;
            PH_LEN_HI: begin
                skip_left = {b, 8'h00};
                parse_phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                skip_left = skip_left | {8'h00, b};
                if (skip_left == 16'h0) next_chunk();
                else parse_phase = PH_SKIP;
            end
            PH_SKIP: begin
                skip_left = skip_left - 16'd1;
                if (skip_left == 16'h0) next_chunk();
            end
            PH_FINAL: begin
                byte_pos = '0;
                size_acc = '0;
                parse_phase = PH_SIZE;
            end
            PH_SIZE: begin
                size_acc = {size_acc[23:0], b};
                byte_pos = byte_pos + 4'd1;
                if (byte_pos >= SIZE_BYTES) begin
                    byte_pos = '0;
                    parse_phase = PH_PAYLOAD;
                    res.kind = KIND_HEADER;
                    res.config_size = size_acc;
                    hit = 1'b1;
                end
            end
            PH_PAYLOAD: begin
                res.kind = KIND_PAYLOAD;
                res.data_byte = b;
                hit = 1'b1;
            end
            default: ;  // error phase and unused codes drop the byte
        endcase
        return hit;
    endfunction

    // drives one word, waits for it to be taken, then queues what it should give
    task automatic push_byte(input logic [7:0] b, input logic s, input bit pinned,
                             input t_result pin_res);
        t_result res;
        bit      hit;
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_byte_value <= b;
        i_starts_file <= s;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        words_sent++;
        hit = parse_byte(b, s, res);
        if (pinned) pending_results.push_back(pin_res);
        else if (hit) pending_results.push_back(res);
    endtask

    task automatic send_file(input bit bad_magic, input bit truncate, input bit huge);
        logic [7:0]  fb [$];
        logic [15:0] len;
        logic [31:0] size_val;
        int          idx;
        int          n;
        int          pick;
        for (int i = 0; i < MAGIC_LEN; i++) fb.push_back(magic_seq[i]);
        if (bad_magic) begin
            idx = $urandom_range(0, MAGIC_LEN - 1);
            fb[idx] = fb[idx] ^ 8'($urandom_range(1, 255));
        end
        for (int c = 0; c < HEADER_CHUNKS_DEF; c++) begin
            pick = $urandom_range(0, 99);
            if (huge) len = (c == 0) ? 16'h0100 : 16'h0000;
            else if (pick < 15) len = 16'h0000;
            else if (pick < 80) len = 16'($urandom_range(1, 6));
            else if (pick < 95) len = 16'($urandom_range(7, 40));
            else len = {8'h01, 8'($urandom)};
            fb.push_back(8'($urandom));
            fb.push_back(len[15:8]);
            fb.push_back(len[7:0]);
            for (int k = 0; k < len; k++) fb.push_back(8'($urandom));
        end
        fb.push_back(8'($urandom));
        pick = $urandom_range(0, 9);
        if (huge || pick == 0) size_val = 32'hFFFF_FFFF;
        else if (pick == 1) size_val = 32'h0;
        else size_val = $urandom;
        for (int k = 3; k >= 0; k--) fb.push_back(size_val[8*k +: 8]);
        n = huge ? 10 : $urandom_range(0, 30);
        for (int k = 0; k < n; k++) fb.push_back(8'($urandom));
        n = fb.size();
        // a cut file leaves the parser mid-phase for the next start to clear
        if (bad_magic) n = MAGIC_LEN + $urandom_range(0, 5);
        else if (truncate) n = $urandom_range(1, fb.size() - 1);
        for (int i = 0; i < n; i++) push_byte(fb[i], i == 0, 1'b0, NO_RES);
        files_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // receiver stall bursts at random, none once calm is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 2);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_kind, o_data_byte, o_config_size};
            case (got.kind)
                KIND_HEADER:   seen_headers++;
                KIND_MISMATCH: seen_mismatches++;
                default:       seen_payload++;
            endcase
            if (pending_results.size() == 0) begin
                $error("unexpected result: kind %0d data_byte %0h config_size %0h",
                       got.kind, got.data_byte, got.config_size);
                mon_errors++;
            end else begin
                want = pending_results.pop_front();
                if (got.kind != want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, got.kind);
                    mon_errors++;
                end
                if (got.data_byte != want.data_byte) begin
                    $error("data_byte: expected %0h, got %0h", want.data_byte, got.data_byte);
                    mon_errors++;
                end
                if (got.config_size != want.config_size) begin
                    $error("config_size: expected %0h, got %0h",
                           want.config_size, got.config_size);
                    mon_errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no word moved for %0d cycles", idle_cycles);
            $display("bitstream_header_parser_tb: FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int  roll;
        bit  drained;
        drained = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_ROWS; r++)
            push_byte(dir_rows[r].b, dir_rows[r].s, dir_rows[r].pinned, dir_rows[r].res);

        while (words_sent < RANDOM_WORDS) begin
            if (!drained && words_sent >= RANDOM_WORDS / 2) begin
                drain_results();
                drained = 1'b1;
            end
            calm = (words_sent >= CALM_FROM);
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                repeat ($urandom_range(1, 4))
                    push_byte(8'($urandom), $urandom_range(0, 3) == 0, 1'b0, NO_RES);
            end else if (roll < 16) begin
                send_file(1'b1, 1'b0, 1'b0);
            end else if (roll < 30) begin
                send_file(1'b0, 1'b1, 1'b0);
            end else begin
                send_file(1'b0, 1'b0, 1'b0);
            end
        end
        // one file with a long chunk and the largest size
        calm = 1'b1;
        send_file(1'b0, 1'b0, 1'b1);

        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);

        $display("run covered %0d words over %0d files and noise bursts", words_sent, files_sent);
        $display("results checked: %0d headers, %0d mismatches, %0d payload bytes",
                 seen_headers, seen_mismatches, seen_payload);
        if (mon_errors == 0) begin
            $display("bitstream_header_parser_tb: PASS");
        end else begin
            $display("bitstream_header_parser_tb: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/bhp_pkg.sv
design/bhp_parser.sv
design/bhp_out_buf.sv
design/bitstream_header_parser.sv
tb/bitstream_header_parser_tb.sv
